>>> hw/rtl/mca_pkg.sv
// Shared types, constants and helpers for the countdown alarm table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mca_pkg;

   localparam int SLOTS      = 16;
   localparam int COUNT_BITS = 16;
   localparam int TAG_BITS   = 16;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] KIND_ADDED    = 3'd0;
   localparam logic [2:0] KIND_BADCOUNT = 3'd1;
   localparam logic [2:0] KIND_FULL     = 3'd2;
   localparam logic [2:0] KIND_EXPIRED  = 3'd3;
   localparam logic [2:0] KIND_IDLE     = 3'd4;
   localparam logic [2:0] KIND_CLEARED  = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] start_count;
      logic [15:0] alarm_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  slot;
      logic [15:0] tag_out;
      logic        last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // request taken this cycle
      logic load;     // load the single result of the request
      logic emit;     // load the next pending expiry
   } mca_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fire_any;   // a tick now would expire at least one alarm
      logic pend_last;  // at most one expiry left to report
   } mca_stat_type;

   // lowest set bit of a slot vector
   function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = SLOT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/mca_ctrl.sv
// Controller for the countdown alarm table: request handshake, result valid
// and the expiry drain sequence. Depends on mca_pkg.
`timescale 1ns / 1ps

module mca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mca_pkg::mca_cmd_type  dp_cmd,
   input  mca_pkg::mca_stat_type dp_stat
);
   import mca_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req_ready     = (state_ff == ST_IDLE) && out_free;
      dp_cmd.accept = req_ready && req_valid;
      dp_cmd.load   = dp_cmd.accept &&
                      ((req_cmd == CMD_ADD) || (req_cmd == CMD_CLEAR) ||
                       ((req_cmd == CMD_TICK) && !dp_stat.fire_any));
      dp_cmd.emit   = (state_ff == ST_EMIT) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.accept && (req_cmd == CMD_TICK) && dp_stat.fire_any) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (dp_cmd.emit && dp_stat.pend_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load || dp_cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/mca_dp.sv
// Datapath for the countdown alarm table: slot flags, counts, tags, the
// pending-expiry mask and the result register. Depends on mca_pkg.
`timescale 1ns / 1ps

module mca_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  mca_pkg::req_type      req_data,
   input  mca_pkg::mca_cmd_type  dp_cmd,
   output mca_pkg::mca_stat_type dp_stat,
   output mca_pkg::rsp_type      rsp_data
);
   import mca_pkg::*;

   logic [SLOTS-1:0]      occ_ff, occ_in;
   logic [SLOTS-1:0]      act_ff, act_in;
   logic [SLOTS-1:0]      pend_ff, pend_in;
   logic [COUNT_BITS-1:0] rem_ff [SLOTS];
   logic [COUNT_BITS-1:0] rem_in [SLOTS];
   logic [TAG_BITS-1:0]   tag_ff [SLOTS];
   logic [TAG_BITS-1:0]   tag_in [SLOTS];
   rsp_type               rsp_ff, rsp_in;

   logic [SLOTS-1:0]      fire;
   logic [SLOT_W-1:0]     free_idx;
   logic [SLOT_W-1:0]     emit_idx;
   logic                  full;
   logic [COUNT_BITS-1:0] cnt;
   logic [TAG_BITS-1:0]   tagv;
   logic                  do_add;
   logic                  do_tick;
   logic                  do_clear;
   rsp_type               single;
   rsp_type               expiry;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         fire[i] = occ_ff[i] && act_ff[i] && (rem_ff[i] == COUNT_BITS'(1));
      end
   end

   assign free_idx = lowest_set(~occ_ff);
   assign emit_idx = lowest_set(pend_ff);
   assign full     = &occ_ff;
   assign cnt      = COUNT_BITS'(req_data.start_count);
   assign tagv     = TAG_BITS'(req_data.alarm_tag);

   assign do_add   = dp_cmd.accept && (req_data.cmd == CMD_ADD) &&
                     (cnt != '0) && !full;
   assign do_tick  = dp_cmd.accept && (req_data.cmd == CMD_TICK);
   assign do_clear = dp_cmd.accept && (req_data.cmd == CMD_CLEAR);

   assign dp_stat.fire_any  = |fire;
   assign dp_stat.pend_last = ((pend_ff & (pend_ff - SLOTS'(1))) == '0);

   // result for requests that answer with one item
   always_comb begin
      single = '{kind: KIND_IDLE, slot: '0, tag_out: '0, last: 1'b1};
      priority if (req_data.cmd == CMD_CLEAR) begin
         single.kind = KIND_CLEARED;
      end else if (req_data.cmd == CMD_TICK) begin
         single.kind = KIND_IDLE;
      end else if (cnt == '0) begin
         single.kind = KIND_BADCOUNT;
      end else if (full) begin
         single.kind = KIND_FULL;
      end else begin
         single.kind = KIND_ADDED;
         single.slot = 6'(free_idx);
      end
   end

   always_comb begin
      expiry.kind    = KIND_EXPIRED;
      expiry.slot    = 6'(emit_idx);
      expiry.tag_out = 16'(tag_ff[emit_idx]);
      expiry.last    = dp_stat.pend_last;
   end

   always_comb begin
      occ_in  = occ_ff;
      act_in  = act_ff;
      pend_in = pend_ff;
      rem_in  = rem_ff;
      tag_in  = tag_ff;
      rsp_in  = rsp_ff;

      if (do_add) begin
         occ_in[free_idx] = 1'b1;
         act_in[free_idx] = 1'b1;
         rem_in[free_idx] = cnt;
         tag_in[free_idx] = tagv;
      end
      if (do_tick) begin
         // all live counts step down together; the ones hitting zero go pending
         for (int i = 0; i < SLOTS; i++) begin
            if (occ_ff[i] && act_ff[i]) begin
               rem_in[i] = rem_ff[i] - COUNT_BITS'(1);
            end
         end
         act_in  = act_ff & ~fire;
         pend_in = fire;
      end
      if (do_clear) begin
         occ_in = '0;
         act_in = '0;
      end

      if (dp_cmd.load) begin
         rsp_in = single;
      end else if (dp_cmd.emit) begin
         rsp_in = expiry;
         pend_in[emit_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         act_ff  <= '0;
         pend_ff <= '0;
      end else begin
         occ_ff  <= occ_in;
         act_ff  <= act_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      tag_ff <= tag_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/multi_slot_countdown_alarms_top.sv
// Top level of the countdown alarm table: controller plus datapath.
// Depends on mca_pkg, mca_ctrl and mca_dp.
//
// Requests come in on req_valid/req_ready/req_data: add an alarm (count, tag),
// tick, or clear all slots. Results leave on rsp_valid/rsp_ready/rsp_data,
// one registered result at a time.
// The result of an add, a clear or a tick that fires nothing is registered
// and shows in the cycle after the request is taken. A tick that expires
// alarms first loads them into the pending mask and moves the controller to
// ST_EMIT; the expiries then leave through the single result register, one
// expiry per cycle while the receiver takes them, in ascending slot order,
// the last one flagged by last. No new request is taken until that drain is
// done. Command code 3 is taken and dropped without a result.
// A new request is taken while the previous result waits, provided the
// receiver takes it in that same cycle; while rsp_ready is low everything
// holds. Reset frees every slot and drops any pending result.
`timescale 1ns / 1ps

module multi_slot_countdown_alarms_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mca_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mca_pkg::rsp_type rsp_data
);
   import mca_pkg::*;

   mca_cmd_type  dp_cmd;
   mca_stat_type dp_stat;

   mca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   mca_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .dp_cmd   (dp_cmd),
      .dp_stat  (dp_stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> hw/rtl/mca_chk.sv
// Port-level checks for the countdown alarm table, bound to the top level.
// Depends on mca_pkg and multi_slot_countdown_alarms_top.
`timescale 1ns / 1ps

module mca_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mca_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mca_pkg::rsp_type rsp_data
);
   import mca_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // only expiries carry a tag or leave the item open
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_EXPIRED) |->
         rsp_data.last && (rsp_data.tag_out == '0))
      else $error("non-expiry result not final or tagged");

   // no new request while a tick still has expiries to report
   a_no_req_midburst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("request taken during expiry burst");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.slot < SLOTS) && (rsp_data.kind <= KIND_CLEARED))
      else $error("result slot or kind out of range");

endmodule

bind multi_slot_countdown_alarms_top mca_chk u_mca_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/alarm_table_checker.sv
// Checker for the countdown alarm table: watches both channels, predicts the
// results of every accepted request and compares them in order.
// Depends on mca_pkg for the payload types and command/result codes.
`timescale 1ns / 1ps

module alarm_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  mca_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  mca_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding
);
   import mca_pkg::*;

   // predicted copy of the alarm table
   logic [SLOTS-1:0]      slot_used;
   logic [SLOTS-1:0]      slot_armed;
   logic [COUNT_BITS-1:0] countdown [SLOTS];
   logic [TAG_BITS-1:0]   owner_tag [SLOTS];

   rsp_type due_results[$];

   function automatic rsp_type alarm_result(input logic [2:0] kind, input int slot,
                                            input logic [15:0] tag, input logic last);
      rsp_type r;
      r.kind    = kind;
      r.slot    = 6'(slot);
      r.tag_out = tag;
      r.last    = last;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic predict_alarm_results(input req_type r);
      logic [COUNT_BITS-1:0] count;
      logic [TAG_BITS-1:0]   tag;
      int                    free_slot;
      int                    fired;
      rsp_type               tail;
      count     = r.start_count[COUNT_BITS-1:0];
      tag       = r.alarm_tag[TAG_BITS-1:0];
      free_slot = -1;
      fired     = 0;
      case (r.cmd)
         CMD_ADD: begin
            if (count == '0) begin
               due_results.push_back(alarm_result(KIND_BADCOUNT, 0, '0, 1'b1));
            end else begin
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  if (!slot_used[i]) free_slot = i;
               end
               if (free_slot < 0) begin
                  due_results.push_back(alarm_result(KIND_FULL, 0, '0, 1'b1));
               end else begin
                  slot_used[free_slot]  = 1'b1;
                  slot_armed[free_slot] = 1'b1;
                  countdown[free_slot]  = count;
                  owner_tag[free_slot]  = tag;
                  due_results.push_back(alarm_result(KIND_ADDED, free_slot, '0, 1'b1));
               end
            end
         end
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_armed[i]) begin
                  countdown[i] = countdown[i] - 1'b1;
                  if (countdown[i] == '0) begin
                     slot_armed[i] = 1'b0;
                     due_results.push_back(alarm_result(KIND_EXPIRED, i, 16'(owner_tag[i]),
                                                        1'b0));
                     fired++;
                  end
               end
            end
            if (fired == 0) begin
               due_results.push_back(alarm_result(KIND_IDLE, 0, '0, 1'b1));
            end else begin
               // final expiry of the tick carries last
               tail      = due_results.pop_back();
               tail.last = 1'b1;
               due_results.push_back(tail);
            end
         end
         CMD_CLEAR: begin
            slot_used  = '0;
            slot_armed = '0;
            due_results.push_back(alarm_result(KIND_CLEARED, 0, '0, 1'b1));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         slot_used  = '0;
         slot_armed = '0;
         due_results.delete();
      end else begin
         // a result never leaves in the cycle its request is taken, so check first
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result, kind", rsp_data.kind, 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_data.kind !== want.kind)
                  report_mismatch("kind", rsp_data.kind, want.kind);
               if (rsp_data.slot !== want.slot)
                  report_mismatch("slot", rsp_data.slot, want.slot);
               if (rsp_data.tag_out !== want.tag_out)
                  report_mismatch("tag_out", rsp_data.tag_out, want.tag_out);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", rsp_data.last, want.last);
            end
         end
         if (req_valid && req_ready) predict_alarm_results(req_data);
      end
      outstanding <= due_results.size();
   end

endmodule

>>> tb/tb_multi_slot_countdown_alarms_top.sv
// Testbench top for the countdown alarm table: clock, reset, request and
// response traffic with random stalls, and the verdict.
// Depends on mca_pkg, multi_slot_countdown_alarms_top and alarm_table_checker.
`timescale 1ns / 1ps

module tb_multi_slot_countdown_alarms_top;
   import mca_pkg::*;

   localparam int         RESET_CYCLES = 6;
   localparam int         RANDOM_ITEMS = 105;
   localparam int         QUIET_TAIL   = 30;
   localparam int         HOLD_START   = 40;
   localparam int         HOLD_ITEMS   = 10;
   localparam int         LONG_HOLD    = 150;
   localparam int         DRAIN_POINT  = 80;
   localparam int         CYCLE_LIMIT  = 300000;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   bit quiet       = 1'b0;
   bit hold_off    = 1'b0;

   multi_slot_countdown_alarms_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   alarm_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random stall bursts, one long hold-off on demand
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // leaves req_valid high; the caller lowers it or offers the next request
   task automatic send_request(input logic [1:0] op, input logic [15:0] count,
                               input logic [15:0] tag);
      req_data  <= '{cmd: op, start_count: count, alarm_tag: tag};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      logic [1:0]  op;
      logic [15:0] count;
      int          pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, zero count, extreme counts and tags,
      // two expiries in one tick, full table, unused command, clear
      send_request(CMD_TICK, 16'h0000, 16'h0000);
      send_request(CMD_ADD, 16'h0000, 16'hFFFF);
      send_request(CMD_ADD, 16'h0001, 16'hFFFF);
      send_request(CMD_ADD, 16'hFFFF, 16'h0000);
      send_request(CMD_ADD, 16'h0002, 16'h1234);
      send_request(CMD_ADD, 16'h0001, 16'hA5A5);
      send_request(CMD_TICK, 16'hFFFF, 16'hFFFF);
      send_request(CMD_TICK, 16'h0000, 16'h0000);
      for (int i = 4; i < SLOTS; i++) send_request(CMD_ADD, 16'h0001, 16'($urandom));
      send_request(CMD_ADD, 16'h0005, 16'h5A5A);
      send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
      send_request(CMD_TICK, 16'h0000, 16'h0000);
      send_request(CMD_CLEAR, 16'h0000, 16'h0000);
      send_request(CMD_ADD, 16'h0003, 16'h8001);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
         if (n == HOLD_START) hold_off = 1'b1;
         if (n == DRAIN_POINT) wait_drained();
         // keep offering back to back while the response side holds off
         if (!quiet && !(n >= HOLD_START && n < HOLD_START + HOLD_ITEMS) &&
             $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 18));
         pick  = $urandom_range(0, 99);
         count = 16'($urandom_range(1, 5));
         if (pick < 50) begin
            op = CMD_ADD;
            case ($urandom_range(0, 19))
               0:       count = 16'h0000;
               1, 2, 3: count = 16'($urandom);
               default: ;
            endcase
         end else if (pick < 93) begin
            op = CMD_TICK;
         end else if (pick < 97) begin
            op = CMD_CLEAR;
         end else begin
            op = CMD_UNUSED;
         end
         send_request(op, count, 16'($urandom));
      end

      wait_drained();
      repeat (SLOTS + 4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mca_pkg.sv
hw/rtl/mca_ctrl.sv
hw/rtl/mca_dp.sv
hw/rtl/multi_slot_countdown_alarms_top.sv
hw/rtl/mca_chk.sv
tb/alarm_table_checker.sv
tb/tb_multi_slot_countdown_alarms_top.sv
